@@ sv/dia_pkg.sv @@
package dia_pkg;

  localparam int DEF_MAX_BINS    = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int BIN_W      = 6;
  localparam int IN_VALUE_W = 32;
  localparam int SCORE_W    = 32;
  localparam int COUNT_W    = 7;
  localparam int RADIUS_W   = 5;
  localparam int DIV_W      = 2 * RADIUS_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd1;

  localparam logic [COUNT_W-1:0]  RST_BIN_COUNT     = 7'd64;
  localparam logic [RADIUS_W-1:0] RST_WINDOW_RADIUS = 5'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

@@ sv/dia_ram.sv @@
module dia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dia_div.sv @@
module dia_div
  import dia_pkg::*;
#(
  parameter int SUM_W = 42
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quotient[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= CNT_W'(SUM_W);
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        // one quotient bit per cycle, restoring
        if (fits) begin
          rem <= DIV_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[DIV_W-1:0];
        end
        quotient <= {quotient[SUM_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/diamond_insulation_score_core.sv @@
// diamond insulation score core
//
// channels: command port (start, busy) carrying req_type, row_index, col_index,
// contact_value and query_bin; a transfer happens when start is high and busy
// is low. config port (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// bin_count (index 0) and window_radius (index 1); cfg_ready is always high.
// result port: done is high for one cycle, with score; score_valid only for valid bins.
//
// a write leaves busy low and no result follows.
// a query raises busy; for a valid bin (w = window_radius) done follows w*w
// reads of the contact memory through its one read port, then one bit a cycle
// through the divider, over VALUE_WIDTH + 10 bits. edge bins and a zero window
// give done straight from the check state, with score 0 and no score_valid.
// busy is low again in the cycle done is shown, so the next command may be
// taken then. the receiver cannot stall; done is never held.
//
// reset clears the control state and sets bin_count 64, window_radius 2.
// the contact memory is not cleared: entries read before written are garbage.
module diamond_insulation_score_core
  import dia_pkg::*;
#(
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [BIN_W-1:0]      row_index,
  input  logic [BIN_W-1:0]      col_index,
  input  logic [IN_VALUE_W-1:0] contact_value,
  input  logic [BIN_W-1:0]      query_bin,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [SCORE_W-1:0]    score,
  output logic                  score_valid
);

  localparam int DEPTH  = MAX_BINS * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = VALUE_WIDTH + DIV_W;
  localparam int CMP_W  = $clog2(MAX_BINS + 128) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SUM,
    S_DIV
  } state_t;

  state_t state;

  logic [COUNT_W-1:0]  bin_count;
  logic [RADIUS_W-1:0] window_radius;

  logic [BIN_W-1:0] bin;
  logic [BIN_W-1:0] row;
  logic [BIN_W-1:0] col;
  logic [BIN_W-1:0] row_last;
  logic [BIN_W-1:0] col_first;
  logic [BIN_W-1:0] col_last;
  logic             issuing;
  logic             issue_valid;
  logic [SUM_W-1:0] sum;
  logic [DIV_W-1:0] divisor;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quotient;

  logic [CMP_W-1:0] side;
  logic             edge_bin;
  logic             accept;
  logic             we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;

  assign busy      = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign side = (CMP_W'(bin_count) > CMP_W'(MAX_BINS)) ? CMP_W'(MAX_BINS)
                                                        : CMP_W'(bin_count);

  assign edge_bin = (window_radius == '0)
                 || (CMP_W'(bin) < CMP_W'(window_radius))
                 || (CMP_W'(bin) + CMP_W'(window_radius) >= side);

  assign we    = accept && (req_type == REQ_WRITE)
              && (CMP_W'(row_index) < side) && (CMP_W'(col_index) < side);
  assign waddr = ADDR_W'(32'(row_index) * MAX_BINS + 32'(col_index));
  assign wdata = VALUE_WIDTH'(contact_value);
  assign raddr = ADDR_W'(32'(row) * MAX_BINS + 32'(col));

  dia_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  dia_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count     <= RST_BIN_COUNT;
      window_radius <= RST_WINDOW_RADIUS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIN_COUNT:     bin_count     <= cfg_data[COUNT_W-1:0];
        CFG_WINDOW_RADIUS: window_radius <= cfg_data[RADIUS_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      score_valid <= 1'b0;
      issuing     <= 1'b0;
      issue_valid <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      done        <= 1'b0;
      score_valid <= 1'b0;
      div_start   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (req_type == REQ_QUERY)) begin
            bin   <= query_bin;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (edge_bin) begin
            score <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            row         <= bin - BIN_W'(window_radius);
            row_last    <= bin - 1'b1;
            col         <= bin + 1'b1;
            col_first   <= bin + 1'b1;
            col_last    <= bin + BIN_W'(window_radius);
            divisor     <= DIV_W'(window_radius) * DIV_W'(window_radius);
            sum         <= '0;
            issuing     <= 1'b1;
            issue_valid <= 1'b0;
            state       <= S_SUM;
          end
        end
        S_SUM: begin
          // address goes out while the previous read is added
          issue_valid <= issuing;
          if (issue_valid) begin
            sum <= sum + SUM_W'(rdata);
          end
          if (issuing) begin
            if (col == col_last) begin
              col <= col_first;
              if (row == row_last) begin
                issuing <= 1'b0;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              col <= col + 1'b1;
            end
          end else if (!issue_valid) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            score       <= SCORE_W'(quotient);
            score_valid <= 1'b1;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/dia_chk.sv @@
module dia_chk
  import dia_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  req_type,
  input logic                  done,
  input logic [SCORE_W-1:0]    score,
  input logic                  score_valid
);

  // a query keeps the block busy until its result
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == REQ_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  // writes give no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == REQ_WRITE) |=> !done)
    else $error("result after a write transfer");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_valid_with_done: assert property (@(posedge clk) disable iff (rst)
    score_valid |-> done)
    else $error("score_valid without done");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !score_valid |-> score == '0)
    else $error("invalid score not zero");

endmodule

bind diamond_insulation_score_core dia_chk u_dia_chk (.*);
